FILE: rtl/wti_pkg.sv
// package for the waypoint trajectory interpolator
// holds the sequencer state type, mode and config codes, divider structs and field widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wti_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned PosW  = 32;
    localparam int unsigned HdgW  = 16;
    localparam int unsigned SegW  = 4;
    localparam int unsigned ModeW = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [ModeW-1:0] MODE_APPEND = 2'd1;
    localparam logic [ModeW-1:0] MODE_TICK   = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_LOOP  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_START = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_Z     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_MOD,
        S_SRCH,
        S_RDA,
        S_RDB,
        S_DIV,
        S_MULX,
        S_MULY,
        S_MULH,
        S_OUT
    } t_state;

    // divider request/status between sequencer and shared divider
    typedef struct packed {
        logic        start;
        logic [5:0]  nbits;
        logic [47:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [47:0] quo;
        logic [31:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: rtl/wti_if.sv
// valid/ready channel interfaces for the interpolator
// depends on wti_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface wti_in_if;
    logic                          valid;
    logic                          ready;
    logic [wti_pkg::ModeW-1:0]     mode;
    logic [wti_pkg::TimeW-1:0]     wp_time;
    logic signed [wti_pkg::PosW-1:0] wp_x;
    logic signed [wti_pkg::PosW-1:0] wp_y;
    logic [wti_pkg::HdgW-1:0]      wp_yaw;
    logic [wti_pkg::TimeW-1:0]     sim_time;
    modport source (output valid, mode, wp_time, wp_x, wp_y, wp_yaw, sim_time,
                    input ready);
    modport sink (input valid, mode, wp_time, wp_x, wp_y, wp_yaw, sim_time,
                  output ready);
endinterface

interface wti_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [wti_pkg::PosW-1:0] pos_x;
    logic signed [wti_pkg::PosW-1:0] pos_y;
    logic signed [wti_pkg::PosW-1:0] pos_z;
    logic [wti_pkg::HdgW-1:0]        heading;
    logic [wti_pkg::SegW-1:0]        segment;
    modport source (output valid, pos_x, pos_y, pos_z, heading, segment, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, heading, segment, output ready);
endinterface
`default_nettype wire

FILE: rtl/wti_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on wti_pkg for request and response structs
`timescale 1ns / 1ps
`default_nettype none
module wti_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wti_pkg::t_div_req i_req,
    output wti_pkg::t_div_rsp      o_rsp
);
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    // shift next numerator bit into the partial remainder
    always_comb begin
        w_sh   = {r_rem[31:0], r_quo[47]};
        w_diff = w_sh - {1'b0, r_den};
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_cnt = i_req.nbits;
            n_quo = i_req.num << (6'd48 - i_req.nbits);
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 6'd1;
            if (!w_diff[32]) begin
                n_rem = w_diff;
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp.busy = (r_cnt != '0) || i_req.start;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[31:0];
endmodule
`default_nettype wire

FILE: rtl/waypoint_trajectory_interpolator_core.sv
// top level of the waypoint trajectory interpolator: table, sequencer, multiplier
// depends on wti_pkg, wti_if and wti_div
//
// channel  dir  handshake    payload
// s_in     in   valid/ready  mode, wp_time, wp_x, wp_y, wp_yaw, sim_time
// m_out    out  valid/ready  pos_x, pos_y, pos_z, heading, segment
// cfg      in   i_cfg_we     i_cfg_idx, i_cfg_data
//
// clear and append complete when accepted; a tick runs from acceptance to a valid result
// through the serial modulo (32 steps, looping only), the segment walk over the table
// and the serial tau division (48 steps)
// reset empties the table and loads register defaults; table contents are not cleared
// input stalls while a tick is in work or a result waits on the output register
`timescale 1ns / 1ps
`default_nettype none
module waypoint_trajectory_interpolator_core #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [wti_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  wire logic [wti_pkg::CfgDataW-1:0]      i_cfg_data,
    wti_in_if.sink                                 s_in,
    wti_out_if.source                              m_out
);
    localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

    // waypoint memories
    logic [31:0] m_time [MAX_POINTS];
    logic [31:0] m_x    [MAX_POINTS];
    logic [31:0] m_y    [MAX_POINTS];
    logic [15:0] m_hdg  [MAX_POINTS];

    wti_pkg::t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic            r_loop;
    logic [31:0]     r_start, r_z;
    logic [31:0]     r_e, n_e;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [IdxW-1:0] r_rd_addr, n_rd_addr;
    logic [31:0]     r_rd_time, r_rd_x, r_rd_y;
    logic [15:0]     r_rd_hdg;
    logic [31:0]     r_ta, n_ta, r_xa, n_xa, r_ya, n_ya;
    logic [15:0]     r_ha, n_ha;
    logic [16:0]     r_tau, n_tau;
    logic signed [33:0] r_mul_a, n_mul_a;
    logic signed [51:0] r_prod;
    logic [31:0]     r_ox, n_ox, r_oy, n_oy;
    logic [15:0]     r_oh, n_oh;
    logic [IdxW-1:0] r_oseg, n_oseg;
    logic            r_ovld, n_ovld;
    logic            r_mul_go, n_mul_go;
    wti_pkg::t_div_req w_req;
    wti_pkg::t_div_rsp w_rsp;
    logic            w_acc, w_wr;
    logic [32:0]     w_num, w_span;
    logic [16:0]     w_hd;
    logic [32:0]     w_elapsed;
    logic signed [51:0] w_rnd;

    assign w_acc = s_in.valid && s_in.ready;
    assign w_wr  = w_acc && (s_in.mode == wti_pkg::MODE_APPEND)
                   && (r_count < CntW'(MAX_POINTS));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop  <= 1'b1;
            r_start <= '0;
            r_z     <= 32'd55706;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wti_pkg::CFG_LOOP:  r_loop  <= i_cfg_data[0];
                wti_pkg::CFG_START: r_start <= i_cfg_data;
                wti_pkg::CFG_Z:     r_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            m_time[r_count[IdxW-1:0]] <= s_in.wp_time;
            m_x[r_count[IdxW-1:0]]    <= s_in.wp_x;
            m_y[r_count[IdxW-1:0]]    <= s_in.wp_y;
            m_hdg[r_count[IdxW-1:0]]  <= s_in.wp_yaw;
        end
        r_rd_time <= m_time[r_rd_addr];
        r_rd_x    <= m_x[r_rd_addr];
        r_rd_y    <= m_y[r_rd_addr];
        r_rd_hdg  <= m_hdg[r_rd_addr];
    end

    // registered multiplier with rounding bias
    always_ff @(posedge i_clk) begin
        r_prod <= r_mul_a * $signed({35'd0, r_tau}) + 52'sd32768;
    end
    assign w_rnd = r_prod >>> 16;

    assign w_elapsed = {1'b0, s_in.sim_time} - {1'b0, r_start};
    assign w_num  = {1'b0, r_e} - {1'b0, r_ta};
    assign w_span = {1'b0, r_rd_time} - {1'b0, r_ta};
    assign w_hd   = {1'b0, r_rd_hdg - r_ha};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_e      = r_e;
        n_idx    = r_idx;
        n_rd_addr = r_rd_addr;
        n_ta = r_ta; n_xa = r_xa; n_ya = r_ya; n_ha = r_ha;
        n_tau    = r_tau;
        n_mul_a  = r_mul_a;
        n_ox = r_ox; n_oy = r_oy; n_oh = r_oh; n_oseg = r_oseg;
        n_ovld   = r_ovld && !m_out.ready;
        n_mul_go = 1'b0;
        w_req    = '0;
        case (r_state)
            wti_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (s_in.mode)
                        wti_pkg::MODE_CLEAR: n_count = '0;
                        wti_pkg::MODE_APPEND: begin
                            if (w_wr) n_count = r_count + CntW'(1);
                        end
                        wti_pkg::MODE_TICK: begin
                            if (r_count >= CntW'(2)) begin
                                n_e = w_elapsed[32] ? 32'd0 : w_elapsed[31:0];
                                n_rd_addr = IdxW'(r_count - CntW'(1));
                                n_state = wti_pkg::S_LAST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            wti_pkg::S_LAST: begin
                // last time arrives next cycle
                n_state = wti_pkg::S_MOD;
            end
            wti_pkg::S_MOD: begin
                if (r_loop && r_rd_time != '0) begin
                    w_req.start = 1'b1;
                    w_req.nbits = 6'd32;
                    w_req.num   = {16'd0, r_e};
                    w_req.den   = r_rd_time;
                    n_state = wti_pkg::S_SRCH;
                    n_idx = '0;
                    n_rd_addr = IdxW'(1);
                    n_tau = 17'd1; // marks modulo pending
                end else begin
                    if (r_e >= r_rd_time) n_e = r_rd_time;
                    n_idx = '0;
                    n_rd_addr = IdxW'(1);
                    n_tau = 17'd2; // hold in S_SRCH until time[1] is read
                    n_state = wti_pkg::S_SRCH;
                end
            end
            wti_pkg::S_SRCH: begin
                // wait for modulo, then walk: r_rd_time is time[idx+1]
                if (r_tau[0]) begin
                    if (!w_rsp.busy) begin
                        n_e = w_rsp.rem;
                        n_tau = '0;
                    end
                end else if ((CntW'(r_idx) + CntW'(2) < r_count)
                             && r_e > r_rd_time) begin
                    n_idx = r_idx + IdxW'(1);
                    n_rd_addr = r_idx + IdxW'(2);
                    n_state = wti_pkg::S_SRCH;
                    n_tau = 17'd2; // hold in S_SRCH for the registered read
                end else begin
                    n_rd_addr = r_idx;
                    n_state = wti_pkg::S_RDA;
                end
                if (r_tau[1]) begin
                    n_tau = '0;
                end
                if (r_tau[1] && !r_tau[0]) begin
                    n_idx = r_idx; n_rd_addr = r_rd_addr; n_state = wti_pkg::S_SRCH;
                end
            end
            wti_pkg::S_RDA: begin
                n_state = wti_pkg::S_RDB;
                n_rd_addr = r_idx + IdxW'(1);
            end
            wti_pkg::S_RDB: begin
                n_ta = r_rd_time; n_xa = r_rd_x; n_ya = r_rd_y; n_ha = r_rd_hdg;
                n_state = wti_pkg::S_DIV;
                n_tau = 17'd1;
            end
            wti_pkg::S_DIV: begin
                // r_rd_* now holds point b
                if (r_tau[0]) begin
                    n_tau = 17'd2;
                    if (w_num[32] || w_num == '0) begin
                        n_tau = '0;
                        n_mul_go = 1'b1;
                    end else if ((w_span[32] || w_span == '0) ? 1'b1 : (w_num >= w_span)) begin
                        if (!(w_span[32] || w_span == '0) || w_num >= 33'd1) begin
                            n_tau = 17'h10000;
                            n_mul_go = 1'b1;
                        end
                    end else begin
                        w_req.start = 1'b1;
                        w_req.nbits = 6'd48;
                        w_req.num   = {w_num[31:0], 16'd0};
                        w_req.den   = w_span[31:0];
                    end
                end else if (r_mul_go) begin
                    n_mul_a = $signed({{2{r_rd_x[31]}}, r_rd_x}) - $signed({{2{r_xa[31]}}, r_xa});
                    n_state = wti_pkg::S_MULX;
                end else if (!w_rsp.busy) begin
                    n_tau = w_rsp.quo[16:0];
                    n_mul_go = 1'b1;
                end
                if (n_mul_go) begin
                    n_mul_a = $signed({{2{r_rd_x[31]}}, r_rd_x}) - $signed({{2{r_xa[31]}}, r_xa});
                    n_state = wti_pkg::S_MULX;
                end
            end
            wti_pkg::S_MULX: begin
                n_mul_a = $signed({{2{r_rd_y[31]}}, r_rd_y}) - $signed({{2{r_ya[31]}}, r_ya});
                n_state = wti_pkg::S_MULY;
            end
            wti_pkg::S_MULY: begin
                n_ox = r_xa + w_rnd[31:0];
                if (w_hd == 17'h08000) n_mul_a = 34'sd32768;
                else n_mul_a = $signed({{18{w_hd[15]}}, w_hd[15:0]});
                n_state = wti_pkg::S_MULH;
            end
            wti_pkg::S_MULH: begin
                n_oy = r_ya + w_rnd[31:0];
                n_state = wti_pkg::S_OUT;
            end
            wti_pkg::S_OUT: begin
                if (!r_ovld || m_out.ready) begin
                    n_oh = r_ha + w_rnd[15:0];
                    n_oseg = r_idx;
                    n_ovld = 1'b1;
                    n_state = wti_pkg::S_IDLE;
                end
            end
            default: n_state = wti_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wti_pkg::S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
            r_mul_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovld  <= n_ovld;
            r_mul_go <= n_mul_go;
        end
        r_e <= n_e; r_idx <= n_idx; r_rd_addr <= n_rd_addr;
        r_ta <= n_ta; r_xa <= n_xa; r_ya <= n_ya; r_ha <= n_ha;
        r_tau <= n_tau; r_mul_a <= n_mul_a;
        r_ox <= n_ox; r_oy <= n_oy; r_oh <= n_oh; r_oseg <= n_oseg;
    end

    wti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign s_in.ready    = (r_state == wti_pkg::S_IDLE) && !r_ovld;
    assign m_out.valid   = r_ovld;
    assign m_out.pos_x   = r_ox;
    assign m_out.pos_y   = r_oy;
    assign m_out.pos_z   = r_z;
    assign m_out.heading = r_oh;
    assign m_out.segment = wti_pkg::SegW'({{(32 - IdxW){1'b0}}, r_oseg});
endmodule
`default_nettype wire
